// ----- design/ppd_pkg.sv -----
package ppd_pkg;

   localparam int RecordBits = 256;
   localparam int SquareCount = 81;
   localparam int HandSlots = 14;

   typedef enum logic [2:0] {
      KIND_TURN   = 3'd0,
      KIND_SQUARE = 3'd1,
      KIND_HAND   = 3'd2,
      KIND_STATUS = 3'd3,
      KIND_KBLACK = 3'd4,
      KIND_KWHITE = 3'd5
   } kind_type;

   typedef enum logic [6:0] {
      PH_TURN    = 7'b0000001,
      PH_KBLACK  = 7'b0000010,
      PH_KWHITE  = 7'b0000100,
      PH_CODE    = 7'b0001000,
      PH_PROMOTE = 7'b0010000,
      PH_COLOUR  = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       record_start;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] position;
      logic [6:0] content;
      logic       last;
   } result_type;

   // piece type for a complete code, 4'hf while the code is still open
   function automatic logic [3:0] match_code(input logic [5:0] code, input logic [2:0] len);
      logic [3:0] t;
      t = 4'hf;
      if (len == 3'd1 && code == 6'h00) t = 4'd0;
      else if (len == 3'd2 && code == 6'h01) t = 4'd1;
      else if (len == 3'd4 && code == 6'h03) t = 4'd2;
      else if (len == 3'd4 && code == 6'h0b) t = 4'd3;
      else if (len == 3'd4 && code == 6'h07) t = 4'd4;
      else if (len == 3'd5 && code == 6'h0f) t = 4'd7;
      else if (len == 3'd6 && code == 6'h1f) t = 4'd5;
      else if (len == 3'd6 && code == 6'h3f) t = 4'd6;
      else if (len >= 3'd6) t = 4'd0;
      return t;
   endfunction

endpackage

// ----- design/packed_position_huffman_decoder.sv -----
// packed position record decoder
// req_ channel: one record byte per transaction, bits used lsb first;
//   req_tuser marks the first byte of a record and clears the decoder.
// rsp_ channel: one result per transaction (kind, position, content),
//   rsp_tlast set on the final result caused by a byte.
// a 2-entry queue sits between the byte intake and the bit decoder.
// the decoder loads a byte from the queue, then takes one record bit per cycle
// while rsp_ does not hold it back; after the last bit of a record it sends a
// held result, the 14 hand counts and the status result.
// each result waits in a hold register until the next result of the same
// byte settles or the byte ends.
// a byte whose bits settle nothing yields no transaction.
// bytes after a finished record without req_tuser are dropped silently.
// a stalled rsp_ side holds the result and hold registers and stops the
// decoder once both are full, while the queue keeps taking bytes until full.
// reset is synchronous, active high, and clears all state but the data registers.
module packed_position_huffman_decoder #(
   parameter int RecordBits = ppd_pkg::RecordBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // stream_byte
   input  logic        req_tuser,   // record_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // kind[2:0], position[9:3], content[16:10], pad
   output logic        rsp_tlast
);
   ppd_pkg::item_type   qi, qo;
   logic                full, empty, pop;
   ppd_pkg::result_type res;

   assign qi = '{stream_byte: req_tdata, record_start: req_tuser};
   assign req_tready = !full;

   ppd_fifo #(.Depth(2)) u_fifo (
      .clock(clock), .reset(reset),
      .push(req_tvalid), .push_data(qi), .full(full),
      .pop(pop), .pop_data(qo), .empty(empty)
   );

   ppd_core #(.RecordBits(RecordBits)) u_core (
      .clock(clock), .reset(reset),
      .item_valid(!empty), .item(qo), .item_pop(pop),
      .res_valid(rsp_tvalid), .res(res), .res_ready(rsp_tready)
   );

   assign rsp_tdata = {7'd0, res.content, res.position, res.kind};
   assign rsp_tlast = res.last;
endmodule

// ----- design/ppd_fifo.sv -----
module ppd_fifo #(
   parameter int Depth = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ppd_pkg::item_type   push_data,
   output logic                full,
   input  logic                pop,
   output ppd_pkg::item_type   pop_data,
   output logic                empty
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   ppd_pkg::item_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full = (cnt_ff == (AW+1)'(Depth));
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in = (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_in = (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) cnt_in = cnt_ff + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end
endmodule

// ----- design/ppd_core.sv -----
module ppd_core #(
   parameter int RecordBits = ppd_pkg::RecordBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  ppd_pkg::item_type    item,
   output logic                 item_pop,
   output logic                 res_valid,
   output ppd_pkg::result_type  res,
   input  logic                 res_ready
);
   localparam int BW = $clog2(RecordBits) + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_BITS = 4'b0010,
      ST_HAND = 4'b0100,
      ST_STAT = 4'b1000
   } st_type;

   st_type             st_ff, st_in;
   ppd_pkg::phase_type ph_ff, ph_in;
   logic [BW-1:0] bp_ff, bp_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] bi_ff, bi_in;
   logic [5:0] cs_ff, cs_in;
   logic [2:0] cl_ff, cl_in;
   logic [4:0] pp_ff, pp_in;
   logic [6:0] sq_ff, sq_in;
   logic [6:0] kb_ff, kb_in;
   logic [6:0] kw_ff, kw_in;
   logic [3:0] hs_ff, hs_in;
   logic [6:0] hand_ff [ppd_pkg::HandSlots];
   logic       hinc;
   logic [3:0] hslot;
   logic       hclr;

   logic       ov_ff, ov_in;
   ppd_pkg::result_type o_ff, o_in;
   logic       hv_ff, hv_in;
   ppd_pkg::result_type hold_ff, hold_in;

   logic       b, rec_end, emit;
   ppd_pkg::result_type r;
   logic [3:0] t;
   logic [5:0] cs_new;
   logic [2:0] cl_new;
   logic [6:0] sq_next;
   logic       can_out, bit_go;

   // first square at or after s that holds no king
   function automatic logic [6:0] first_free(input logic [6:0] s, input logic [6:0] k0,
                                             input logic [6:0] k1);
      logic [6:0] n;
      n = s;
      for (int i = 0; i < 2; i++) begin
         if (n < 7'(ppd_pkg::SquareCount) && (n == k0 || n == k1)) n = n + 7'd1;
      end
      return n;
   endfunction

   assign res_valid = ov_ff;
   assign res = o_ff;
   assign can_out = !ov_ff || res_ready;
   assign bit_go = !hv_ff || can_out;
   assign b = byte_ff[bi_ff];
   assign cs_new = cs_ff | (6'(b) << cl_ff);
   assign cl_new = cl_ff + 3'd1;
   assign t = ppd_pkg::match_code(cs_new, cl_new);
   assign sq_next = first_free(sq_ff + 7'd1, kb_ff, kw_ff);

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; bp_in = bp_ff; byte_in = byte_ff; bi_in = bi_ff;
      cs_in = cs_ff; cl_in = cl_ff; pp_in = pp_ff; sq_in = sq_ff; kb_in = kb_ff;
      kw_in = kw_ff; hs_in = hs_ff;
      ov_in = ov_ff && !res_ready; o_in = o_ff;
      hv_in = hv_ff; hold_in = hold_ff;
      item_pop = 1'b0; hinc = 1'b0; hslot = '0; hclr = 1'b0;
      emit = 1'b0; r = '{kind: ppd_pkg::KIND_TURN, position: '0, content: '0, last: 1'b0};
      rec_end = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (hv_ff && can_out) begin
               // final result of the previous byte
               ov_in = 1'b1; o_in = hold_ff; o_in.last = 1'b1; hv_in = 1'b0;
            end
            if (item_valid && bit_go) begin
               item_pop = 1'b1;
               if (item.record_start) begin
                  ph_in = ppd_pkg::PH_TURN; bp_in = '0; cs_in = '0; cl_in = '0; pp_in = '0;
                  sq_in = '0; kb_in = '0; kw_in = '0; hclr = 1'b1;
                  st_in = ST_BITS;
               end else if (bp_ff < BW'(RecordBits)) begin
                  st_in = ST_BITS;
               end
               byte_in = item.stream_byte; bi_in = '0;
            end
         end
         ST_BITS: begin
            if (bit_go) begin
               case (ph_ff)
                  ppd_pkg::PH_TURN: begin
                     emit = 1'b1; r.kind = ppd_pkg::KIND_TURN; r.content = 7'(b);
                     ph_in = ppd_pkg::PH_KBLACK; cs_in = '0; cl_in = '0;
                  end
                  ppd_pkg::PH_KBLACK, ppd_pkg::PH_KWHITE: begin
                     cs_in = cs_new; cl_in = cl_new;
                     if (cl_ff == 3'd6) begin
                        cs_in = '0; cl_in = '0;
                        emit = 1'b1;
                        r.position = {b, cs_ff};
                        if (ph_ff == ppd_pkg::PH_KBLACK) begin
                           kb_in = {b, cs_ff}; r.kind = ppd_pkg::KIND_KBLACK; r.content = 7'd8;
                           ph_in = ppd_pkg::PH_KWHITE;
                        end else begin
                           kw_in = {b, cs_ff}; r.kind = ppd_pkg::KIND_KWHITE; r.content = 7'd24;
                           sq_in = first_free(7'd0, kb_ff, {b, cs_ff});
                           ph_in = ppd_pkg::PH_CODE;
                        end
                     end
                  end
                  ppd_pkg::PH_CODE: begin
                     cs_in = cs_new; cl_in = cl_new;
                     if (t != 4'hf) begin
                        cs_in = '0; cl_in = '0;
                        if (t == 4'd0) begin
                           if (sq_ff < 7'(ppd_pkg::SquareCount)) begin
                              emit = 1'b1; r.kind = ppd_pkg::KIND_SQUARE; r.position = sq_ff;
                              sq_in = sq_next;
                           end else ph_in = ppd_pkg::PH_DONE;
                        end else begin
                           pp_in = 5'(t);
                           ph_in = (t == 4'd7 || sq_ff >= 7'(ppd_pkg::SquareCount)) ?
                                   ppd_pkg::PH_COLOUR : ppd_pkg::PH_PROMOTE;
                        end
                     end
                  end
                  ppd_pkg::PH_PROMOTE: begin
                     if (b) pp_in = pp_ff + 5'd8;
                     ph_in = ppd_pkg::PH_COLOUR;
                  end
                  ppd_pkg::PH_COLOUR: begin
                     if (sq_ff < 7'(ppd_pkg::SquareCount)) begin
                        emit = 1'b1; r.kind = ppd_pkg::KIND_SQUARE; r.position = sq_ff;
                        r.content = 7'(pp_ff) + (b ? 7'd16 : 7'd0);
                        sq_in = sq_next;
                     end else begin
                        hslot = (b ? 4'd7 : 4'd0) + {1'b0, 3'(pp_ff - 5'd1)};
                        hinc = 1'b1;
                     end
                     pp_in = '0; ph_in = ppd_pkg::PH_CODE;
                  end
                  default: ;
               endcase
               bp_in = bp_ff + BW'(1);
               bi_in = bi_ff + 3'd1;
               rec_end = (bp_ff == BW'(RecordBits - 1));
               if (rec_end) begin
                  st_in = ST_HAND; hs_in = '0;
               end else if (bi_ff == 3'd7) begin
                  st_in = ST_IDLE;
               end
               if (emit) begin
                  if (hv_ff) begin
                     ov_in = 1'b1; o_in = hold_ff;
                  end
                  hv_in = 1'b1; hold_in = r;
               end
            end
         end
         ST_HAND: begin
            if (can_out) begin
               ov_in = 1'b1;
               if (hv_ff) begin
                  o_in = hold_ff; hv_in = 1'b0;
               end else begin
                  o_in = '{kind: ppd_pkg::KIND_HAND, position: 7'(hs_ff),
                           content: hand_ff[hs_ff], last: 1'b0};
                  hs_in = hs_ff + 4'd1;
                  if (hs_ff == 4'(ppd_pkg::HandSlots - 1)) st_in = ST_STAT;
               end
            end
         end
         ST_STAT: begin
            if (can_out) begin
               ov_in = 1'b1;
               o_in = '{kind: ppd_pkg::KIND_STATUS, position: sq_ff,
                        content: (sq_ff >= 7'(ppd_pkg::SquareCount)) ? 7'd1 : 7'd0,
                        last: 1'b1};
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ph_ff <= ppd_pkg::PH_TURN; bp_ff <= '0; ov_ff <= 1'b0;
         cs_ff <= '0; cl_ff <= '0; pp_ff <= '0; sq_ff <= '0; kb_ff <= '0; kw_ff <= '0;
         hv_ff <= 1'b0; hs_ff <= '0;
         for (int i = 0; i < ppd_pkg::HandSlots; i++) hand_ff[i] <= '0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; bp_ff <= bp_in; ov_ff <= ov_in;
         cs_ff <= cs_in; cl_ff <= cl_in; pp_ff <= pp_in; sq_ff <= sq_in; kb_ff <= kb_in;
         kw_ff <= kw_in; hv_ff <= hv_in; hs_ff <= hs_in;
         if (hclr) begin
            for (int i = 0; i < ppd_pkg::HandSlots; i++) hand_ff[i] <= '0;
         end else if (hinc && hslot < 4'(ppd_pkg::HandSlots) && hand_ff[hslot] != 7'd127) begin
            hand_ff[hslot] <= hand_ff[hslot] + 7'd1;
         end
      end
      byte_ff <= byte_in; bi_ff <= bi_in;
      o_ff <= o_in;
      hold_ff <= hold_in;
   end
endmodule

// ----- tb/sv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      D_TURN, D_KBLACK, D_KWHITE, D_CODE, D_PROMOTE, D_COLOUR, D_DONE
   } dec_phase_type;

   typedef struct {
      ppd_pkg::kind_type kind;
      bit [6:0]   position;
      bit [6:0]   content;
      bit         last;
   } decode_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   packed_position_huffman_decoder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata),   // stream_byte
      .req_tuser(req_tuser),   // record_start
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),   // kind, position, content
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   decode_result_type pending_results[$];
   int errors = 0;
   bit quiet = 0;
   int long_hold = 0;
   int idle_cycles = 0;

   // decoder shadow state
   int            bit_pos;
   dec_phase_type dphase;
   bit [6:0]      shift_reg;
   int            code_len;
   bit [4:0]      held_piece;
   int            square;
   bit [6:0]      king_b, king_w;
   bit            turn_bit;
   int            hand[14];

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic void clear_decoder();
      bit_pos = 0; dphase = D_TURN; shift_reg = 0; code_len = 0; held_piece = 0;
      square = 0; king_b = 0; king_w = 0; turn_bit = 0;
      foreach (hand[i]) hand[i] = 0;
   endfunction

   function automatic void add_result(ppd_pkg::kind_type k, int p, int c);
      decode_result_type r;
      r.kind = k; r.position = p[6:0]; r.content = c[6:0]; r.last = 0;
      pending_results.push_back(r);
   endfunction

   function automatic int piece_of(bit [5:0] c, int len);
      if (len == 1 && c == 6'h00) return 0;
      if (len == 2 && c == 6'h01) return 1;
      if (len == 4 && c == 6'h03) return 2;
      if (len == 4 && c == 6'h0b) return 3;
      if (len == 4 && c == 6'h07) return 4;
      if (len == 5 && c == 6'h0f) return 7;
      if (len == 6 && c == 6'h1f) return 5;
      if (len == 6 && c == 6'h3f) return 6;
      if (len >= 6) return 0;
      return -1;
   endfunction

   function automatic void skip_kings();
      while (square < ppd_pkg::SquareCount && (square == king_b || square == king_w))
         square++;
   endfunction

   function automatic void take_bit(bit b);
      int t;
      int slot;
      bit_pos++;
      case (dphase)
         D_TURN: begin
            turn_bit = b;
            add_result(ppd_pkg::KIND_TURN, 0, b);
            dphase = D_KBLACK; shift_reg = 0; code_len = 0;
         end
         D_KBLACK, D_KWHITE: begin
            shift_reg[code_len] = b;
            code_len++;
            if (code_len >= 7) begin
               if (dphase == D_KBLACK) begin
                  king_b = shift_reg;
                  add_result(ppd_pkg::KIND_KBLACK, king_b, 8);
                  dphase = D_KWHITE;
               end else begin
                  king_w = shift_reg;
                  add_result(ppd_pkg::KIND_KWHITE, king_w, 24);
                  square = 0;
                  skip_kings();
                  dphase = D_CODE;
               end
               shift_reg = 0; code_len = 0;
            end
         end
         D_CODE: begin
            shift_reg[code_len] = b;
            code_len++;
            t = piece_of(shift_reg[5:0], code_len);
            if (t >= 0) begin
               shift_reg = 0; code_len = 0;
               if (t == 0) begin
                  if (square < ppd_pkg::SquareCount) begin
                     add_result(ppd_pkg::KIND_SQUARE, square, 0);
                     square++;
                     skip_kings();
                  end else begin
                     dphase = D_DONE;
                  end
               end else begin
                  held_piece = 5'(t);
                  dphase = (t == 7 || square >= ppd_pkg::SquareCount) ? D_COLOUR : D_PROMOTE;
               end
            end
         end
         D_PROMOTE: begin
            if (b) held_piece = held_piece + 5'd8;
            dphase = D_COLOUR;
         end
         D_COLOUR: begin
            if (square < ppd_pkg::SquareCount) begin
               add_result(ppd_pkg::KIND_SQUARE, square, held_piece + (b ? 16 : 0));
               square++;
               skip_kings();
            end else begin
               slot = b * 7 + ((held_piece - 5'd1) & 5'd7);
               if (slot < ppd_pkg::HandSlots && hand[slot] < 127) hand[slot]++;
            end
            held_piece = 0;
            dphase = D_CODE;
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_byte(bit [7:0] b, bit start);
      int n0;
      if (start) clear_decoder();
      if (bit_pos >= ppd_pkg::RecordBits) return;
      n0 = pending_results.size();
      for (int i = 0; i < 8 && bit_pos < ppd_pkg::RecordBits; i++) take_bit(b[i]);
      if (bit_pos >= ppd_pkg::RecordBits) begin
         for (int i = 0; i < ppd_pkg::HandSlots; i++)
            add_result(ppd_pkg::KIND_HAND, i, hand[i]);
         add_result(ppd_pkg::KIND_STATUS, square, square >= ppd_pkg::SquareCount ? 1 : 0);
      end
      if (pending_results.size() > n0)
         pending_results[pending_results.size() - 1].last = 1;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input bit [7:0] b, input bit start);
      int gap;
      bit ready_seen;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      req_tuser <= start;
      ready_seen = req_tready;
      while (!ready_seen) begin
         @(negedge clock);
         ready_seen = req_tready;
      end
      @(posedge clock);
      predict_byte(b, start);
      @(negedge clock);
   endtask

   function automatic void put_bits(inout bit [255:0] r, inout int p, input int v,
                                    input int len);
      for (int j = 0; j < len; j++) begin
         if (p < 256) r[p] = v[j];
         p++;
      end
   endfunction

   function automatic bit [255:0] build_record();
      int code_val[8] = '{0, 1, 3, 11, 7, 31, 63, 15};
      int code_len_of[8] = '{1, 2, 4, 4, 4, 6, 6, 5};
      bit [255:0] r;
      int p, kb, kw, left, t, mode;
      for (int i = 0; i < 8; i++) r[i*32 +: 32] = $urandom;
      p = 0;
      put_bits(r, p, $urandom_range(0, 1), 1);
      mode = $urandom_range(0, 7);
      kb = $urandom_range(0, 80);
      kw = (mode == 0) ? kb : $urandom_range(0, 80);
      if (mode == 1) kb = $urandom_range(81, 127);
      if (mode == 2) kw = $urandom_range(81, 127);
      put_bits(r, p, kb, 7);
      put_bits(r, p, kw, 7);
      left = 81 - (kb < 81) - (kw < 81 && kw != kb);
      while (p < 256) begin
         if (left > 0) begin
            t = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
            put_bits(r, p, code_val[t], code_len_of[t]);
            if (t != 0) begin
               if (t != 7) put_bits(r, p, $urandom_range(0, 1), 1);
               put_bits(r, p, $urandom_range(0, 1), 1);
            end
            left--;
         end else if ($urandom_range(0, 9) == 0) begin
            put_bits(r, p, 0, 1);
            break;
         end else begin
            t = $urandom_range(1, 7);
            put_bits(r, p, code_val[t], code_len_of[t]);
            put_bits(r, p, $urandom_range(0, 1), 1);
         end
      end
      return r;
   endfunction

   task automatic send_record(input bit [255:0] r, input bit first_start);
      for (int i = 0; i < 32; i++) send_byte(r[i*8 +: 8], i == 0 ? first_start : 1'b0);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      wait (pending_results.size() == 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic test_directed();
      // first record without a start flag, all empties, both kings on square 0
      send_record('0, 1'b0);
      // bytes past the end are ignored
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
      // all ones: kings at 127, rooks until truncation
      send_record({256{1'b1}}, 1'b1);
      drain();
   endtask

   task automatic test_random();
      for (int n = 0; n < 12; n++) begin
         quiet = (n % 4 == 3);
         send_record(build_record(), 1'b1);
         if ($urandom_range(0, 1)) send_byte(8'($urandom), 1'b0);
      end
      quiet = 0;
      // noise, occasionally restarting mid-record
      for (int n = 0; n < 50; n++)
         send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      drain();
   endtask

   task automatic test_backpressure();
      long_hold = 1500;
      quiet = 1;
      send_record(build_record(), 1'b1);
      quiet = 0;
      drain();
   endtask

   // result side
   bit got_one = 0;
   int rsp_wait = 0;
   always @(posedge clock) begin
      decode_result_type e;
      got_one = 0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_one = 1;
         if (pending_results.size() == 0) begin
            report("result with nothing expected");
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata[2:0] != e.kind) report($sformatf("kind %0d exp %0d",
               rsp_tdata[2:0], e.kind));
            if (rsp_tdata[9:3] != e.position) report($sformatf("position %0d exp %0d",
               rsp_tdata[9:3], e.position));
            if (rsp_tdata[16:10] != e.content)
               report($sformatf("content %0d exp %0d", rsp_tdata[16:10], e.content));
            if (rsp_tlast != e.last) report($sformatf("last %0b exp %0b",
               rsp_tlast, e.last));
         end
      end
   end

   always @(negedge clock) begin
      if (got_one) rsp_wait = quiet ? 0 : $urandom_range(0, 16);
      if (long_hold > 0) begin
         rsp_tready <= 0;
         long_hold--;
      end else if (rsp_wait > 0) begin
         rsp_tready <= 0;
         rsp_wait--;
      end else begin
         rsp_tready <= 1;
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (pending_results.size() == 0 && !req_tvalid))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= 8000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      clear_decoder();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random();
      test_backpressure();
      drain();
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
